// File: rtl/core/gsps_pkg.sv
// Package for the gas sensor poll sequencer: sequence phases, request and
// event codes, command words, default timing constants and the CRC-8 helpers.
// No dependencies.
package gsps_pkg;

    // Default timing, in millisecond ticks.
    localparam int unsigned START_DELAY_DEF    = 100;
    localparam int unsigned ERROR_BACKOFF_DEF  = 500;
    localparam int unsigned COMMAND_DELAY_DEF  = 30;
    localparam int unsigned MEASURE_PERIOD_DEF = 1000;

    // Request kinds carried in the input tuser.
    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_XFER_DONE = 2'd1;
    localparam logic [1:0] REQ_MEASURE   = 2'd2;

    // Event codes in the result.
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_UPDATE = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEVICE_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_HUMIDITY_COMP   = 2'd1;
    localparam logic [1:0] CFG_UPDATE_INTERVAL = 2'd2;

    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd88;

    // Command words sent to the sensor.
    localparam logic [15:0] CMD_FEATURE_SET = 16'h202F;
    localparam logic [15:0] CMD_INIT_AQ     = 16'h2003;
    localparam logic [15:0] CMD_SET_HUM     = 16'h2061;
    localparam logic [15:0] CMD_MEASURE     = 16'h2008;

    localparam logic [7:0] FEATURE_HI      = 8'h00;
    localparam logic [7:0] FEATURE_LO_A    = 8'h20;
    localparam logic [7:0] FEATURE_LO_B    = 8'h22;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    typedef enum logic [2:0] {
        PH_FEATURE_WRITE = 3'd0,
        PH_FEATURE_READ  = 3'd1,
        PH_INIT_AQ       = 3'd2,
        PH_HUMIDITY      = 3'd3,
        PH_MEASURE       = 3'd4,
        PH_READ_AQ       = 3'd5
    } t_phase;

    // One byte of CRC-8, MSB first, no final xor.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC over a 16-bit word, high byte first.
    function automatic logic [7:0] crc8_word(input logic [15:0] w);
        return crc8_byte(crc8_byte(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // True when a word followed by its CRC byte checks out.
    function automatic logic crc8_good(input logic [23:0] w);
        return crc8_byte(crc8_word(w[23:8]), w[7:0]) == 8'h00;
    endfunction

endpackage

// File: rtl/core/gas_sensor_poll_sequencer.sv
// Top level of the gas sensor poll sequencer: input register, sequencer state
// update and result register in one module.
// Depends on gsps_pkg.
//
// Usage: each request on the slave stream is a millisecond tick, a bus transfer
// completion (with up to six received bytes) or a measure request; the kind is
// in tuser. Every request yields exactly one result on the master stream. A
// result tells the attached I2C master whether to start a new transfer (and
// which one), and always shows the latched CO2eq and TVOC words, the valid and
// error flags, and an event code for interval expiry or measure requests.
// Timing: a request accepted by the block is held in the input register and
// its result is loaded into the output register when that register is free.
// Throughput: one request per cycle while the receiver keeps tready high; the
// whole sequencer update is a single pass of logic between the two registers.
// Stalls: when the receiver holds tready low, the result waits in the output
// register and one more request is still taken into the input register; only
// then does o_s_axis_tready drop.
// Reset (synchronous, active low) restarts the sequence at the feature-set
// step with the start delay, clears readings and flags, and restores the
// register defaults (address 88, humidity word 0, interval off).
// Configuration writes are taken on any cycle with i_cfg_we high and must be
// issued while no request is in flight.
module gas_sensor_poll_sequencer
    import gsps_pkg::*;
#(
    parameter int unsigned START_DELAY    = START_DELAY_DEF,
    parameter int unsigned ERROR_BACKOFF  = ERROR_BACKOFF_DEF,
    parameter int unsigned COMMAND_DELAY  = COMMAND_DELAY_DEF,
    parameter int unsigned MEASURE_PERIOD = MEASURE_PERIOD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [0] xfer_ok, [48:1] read_bytes, [55:49] zero
    input  logic [55:0] i_s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  i_s_axis_tuser,
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] xfer_start, [1] xfer_read, [8:2] xfer_addr, [11:9] xfer_len,
    // [51:12] xfer_bytes, [67:52] co2eq_ppm, [83:68] tvoc_ppb,
    // [84] reading_valid, [85] error_seen, [87:86] event_code
    output logic [87:0] o_m_axis_tdata,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    localparam logic [15:0] START_DLY = 16'(START_DELAY);
    localparam logic [15:0] BACKOFF   = 16'(ERROR_BACKOFF);
    localparam logic [15:0] CMD_DLY   = 16'(COMMAND_DELAY);
    localparam logic [15:0] PERIOD    = 16'(MEASURE_PERIOD);

    // Configuration registers. The humidity CRC is computed once per write.
    logic [6:0]  r_dev_addr;
    logic [15:0] r_hum;
    logic [7:0]  r_hum_crc;
    logic [31:0] r_interval;

    // Sequencer state.
    t_phase      r_phase,  n_phase;
    logic        r_await,  n_await;
    logic [15:0] r_delay,  n_delay;
    logic [15:0] r_since,  n_since;
    logic [31:0] r_ileft,  n_ileft;
    logic [15:0] r_co2,    n_co2;
    logic [15:0] r_tvoc,   n_tvoc;
    logic        r_valid,  n_valid;
    logic        r_error,  n_error;

    // Input register.
    logic        r_in_valid;
    logic [1:0]  r_in_req;
    logic        r_in_ok;
    logic [47:0] r_in_rb;

    // Output register.
    logic        r_out_valid;
    logic [87:0] r_out_data;

    logic        w_adv;
    logic        w_fail;
    logic [15:0] w_delay_dec;
    logic [1:0]  w_ev_now;
    logic [1:0]  w_ev;
    logic        w_x_start;
    logic        w_x_read;
    logic [2:0]  w_x_len;
    logic [39:0] w_x_bytes;

    // The output register advances when empty or when its result is taken;
    // the input register is free whenever it is empty or advancing.
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Event a measure request or interval expiry would report right now.
    assign w_ev_now = (r_error && !r_valid) ? EV_ERROR :
                      (r_valid ? EV_UPDATE : EV_NONE);

    assign w_delay_dec = (r_delay != 16'd0) ? (r_delay - 16'd1) : 16'd0;

    always_comb begin
        n_phase   = r_phase;
        n_await   = r_await;
        n_delay   = r_delay;
        n_since   = r_since;
        n_ileft   = r_ileft;
        n_co2     = r_co2;
        n_tvoc    = r_tvoc;
        n_valid   = r_valid;
        n_error   = r_error;
        w_fail    = 1'b0;
        w_ev      = EV_NONE;
        w_x_start = 1'b0;
        w_x_read  = 1'b0;
        w_x_len   = 3'd0;
        w_x_bytes = 40'd0;

        if (r_in_valid && w_adv) begin
            case (r_in_req)
                REQ_TICK: begin
                    if (r_since != 16'hFFFF) begin
                        n_since = r_since + 16'd1;
                    end
                    if (r_interval != 32'd0) begin
                        if (r_ileft > 32'd1) begin
                            n_ileft = r_ileft - 32'd1;
                        end else begin
                            n_ileft = r_interval;
                            w_ev    = w_ev_now;
                        end
                    end
                    // The command delay only runs while no transfer is pending.
                    if (!r_await) begin
                        n_delay = w_delay_dec;
                        if (w_delay_dec == 16'd0) begin
                            n_await   = 1'b1;
                            w_x_start = 1'b1;
                            w_x_len   = 3'd2;
                            case (r_phase)
                                PH_FEATURE_WRITE: begin
                                    w_x_bytes = {CMD_FEATURE_SET, 24'd0};
                                end
                                PH_FEATURE_READ: begin
                                    w_x_read = 1'b1;
                                    w_x_len  = 3'd3;
                                end
                                PH_INIT_AQ: begin
                                    w_x_bytes = {CMD_INIT_AQ, 24'd0};
                                end
                                PH_HUMIDITY: begin
                                    w_x_len   = 3'd5;
                                    w_x_bytes = {CMD_SET_HUM, r_hum, r_hum_crc};
                                    n_since   = 16'd0;
                                end
                                PH_MEASURE: begin
                                    w_x_bytes = {CMD_MEASURE, 24'd0};
                                end
                                PH_READ_AQ: begin
                                    w_x_read = 1'b1;
                                    w_x_len  = 3'd6;
                                end
                                default: begin
                                    // An unused phase code is treated as a failure.
                                    n_await   = 1'b0;
                                    w_x_start = 1'b0;
                                    w_x_len   = 3'd0;
                                    w_fail    = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                REQ_XFER_DONE: begin
                    // A completion with nothing pending is ignored.
                    if (r_await) begin
                        n_await = 1'b0;
                        if (!r_in_ok) begin
                            w_fail = 1'b1;
                        end else begin
                            n_delay = CMD_DLY;
                            case (r_phase)
                                PH_FEATURE_WRITE: n_phase = PH_FEATURE_READ;
                                PH_FEATURE_READ: begin
                                    if (!crc8_good(r_in_rb[47:24]) ||
                                        r_in_rb[47:40] != FEATURE_HI ||
                                        (r_in_rb[39:32] != FEATURE_LO_A &&
                                         r_in_rb[39:32] != FEATURE_LO_B)) begin
                                        w_fail = 1'b1;
                                    end else begin
                                        n_phase = PH_INIT_AQ;
                                    end
                                end
                                PH_INIT_AQ: n_phase = PH_HUMIDITY;
                                PH_HUMIDITY: n_phase = PH_MEASURE;
                                PH_MEASURE: n_phase = PH_READ_AQ;
                                PH_READ_AQ: begin
                                    if (!crc8_good(r_in_rb[47:24]) ||
                                        !crc8_good(r_in_rb[23:0])) begin
                                        w_fail = 1'b1;
                                    end else begin
                                        n_co2   = r_in_rb[47:32];
                                        n_tvoc  = r_in_rb[23:8];
                                        n_valid = 1'b1;
                                        n_phase = PH_HUMIDITY;
                                        // Next humidity write falls one period after
                                        // the last one, or at once if that has passed.
                                        n_delay = (r_since >= PERIOD) ? 16'd0 :
                                                  (PERIOD - r_since);
                                    end
                                end
                                default: w_fail = 1'b1;
                            endcase
                        end
                    end
                end
                REQ_MEASURE: begin
                    w_ev = w_ev_now;
                end
                default: begin
                    // Unused request kind: plain status result.
                end
            endcase

            if (w_fail) begin
                n_error = 1'b1;
                n_valid = 1'b0;
                n_phase = PH_FEATURE_WRITE;
                n_await = 1'b0;
                n_delay = BACKOFF;
            end
        end

        // A write of the interval register also reloads the countdown.
        if (i_cfg_we && i_cfg_index == CFG_UPDATE_INTERVAL) begin
            n_ileft = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= DEVICE_ADDRESS_RST;
            r_hum       <= 16'd0;
            r_hum_crc   <= crc8_word(16'd0);
            r_interval  <= 32'd0;
            r_phase     <= PH_FEATURE_WRITE;
            r_await     <= 1'b0;
            r_delay     <= START_DLY;
            r_since     <= 16'd0;
            r_ileft     <= 32'd0;
            r_co2       <= 16'd0;
            r_tvoc      <= 16'd0;
            r_valid     <= 1'b0;
            r_error     <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_await <= n_await;
            r_delay <= n_delay;
            r_since <= n_since;
            r_ileft <= n_ileft;
            r_co2   <= n_co2;
            r_tvoc  <= n_tvoc;
            r_valid <= n_valid;
            r_error <= n_error;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEVICE_ADDRESS: r_dev_addr <= i_cfg_wdata[6:0];
                    CFG_HUMIDITY_COMP: begin
                        r_hum     <= i_cfg_wdata[15:0];
                        r_hum_crc <= crc8_word(i_cfg_wdata[15:0]);
                    end
                    CFG_UPDATE_INTERVAL: begin
                        r_interval <= i_cfg_wdata;
                    end
                    default: begin
                        // Writes beyond the register list are dropped.
                    end
                endcase
            end

            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_req <= i_s_axis_tuser;
            r_in_ok  <= i_s_axis_tdata[0];
            r_in_rb  <= i_s_axis_tdata[48:1];
        end
        if (w_adv && r_in_valid) begin
            r_out_data <= {w_ev, n_error, n_valid, n_tvoc, n_co2, w_x_bytes, w_x_len,
                           (w_x_start ? r_dev_addr : 7'd0), w_x_read, w_x_start};
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for gas_sensor_poll_sequencer: ticks, bus completions and
// measure requests go in, every result is predicted here and compared field by field.
// Depends on gsps_pkg and the RTL top level.
module tb_top;
    import gsps_pkg::*;

    // Request kind that the sequencer must ignore.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // Cycles without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT = 1000;
    // Mismatch lines printed before the rest are only counted.
    localparam int REPORT_CAP = 200;

    // One result word, laid out as on o_m_axis_tdata (first member is the top bits).
    typedef struct packed {
        logic [1:0]  event_code;
        logic        error_seen;
        logic        reading_valid;
        logic [15:0] tvoc_ppb;
        logic [15:0] co2eq_ppm;
        logic [39:0] xfer_bytes;
        logic [2:0]  xfer_len;
        logic [6:0]  xfer_addr;
        logic        xfer_read;
        logic        xfer_start;
    } t_seq_report;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [55:0] s_data;
    logic [1:0]  s_user;
    logic        m_valid;
    logic        m_ready;
    logic [87:0] m_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    // Sequencer state as this testbench sees it, updated as each request is accepted.
    t_phase      seq_phase;
    logic        xfer_pending;
    logic [15:0] wait_ticks;
    logic [15:0] ticks_since_hum;
    logic [31:0] interval_count;
    logic [15:0] latched_co2;
    logic [15:0] latched_tvoc;
    logic        have_reading;
    logic        had_error;
    // Register copies.
    logic [6:0]  cfg_addr;
    logic [15:0] cfg_hum;
    logic [31:0] cfg_interval;

    t_seq_report due_reports[$];
    int          mismatches;
    int          quiet_cycles;
    int          stall_left;
    bit          no_idle;

    gas_sensor_poll_sequencer u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    // CRC-8 over one byte, polynomial 0x31, MSB first.
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        return c;
    endfunction

    function automatic logic [7:0] crc_pair(input logic [7:0] hi, input logic [7:0] lo);
        return crc_update(crc_update(CRC_INIT, hi), lo);
    endfunction

    // What a measure request or an interval expiry reports.
    function automatic logic [1:0] event_now();
        if (had_error && !have_reading) return EV_ERROR;
        if (have_reading) return EV_UPDATE;
        return EV_NONE;
    endfunction

    // Any failure: flag it, drop the reading and restart after the back-off.
    function automatic void enter_backoff();
        had_error    = 1'b1;
        have_reading = 1'b0;
        seq_phase    = PH_FEATURE_WRITE;
        xfer_pending = 1'b0;
        wait_ticks   = 16'(ERROR_BACKOFF_DEF);
    endfunction

    // Advances the state by one accepted request and returns the result it causes.
    function automatic t_seq_report sequencer_step(input logic [1:0] kind, input logic ok,
                                                   input logic [47:0] rx);
        t_seq_report r;
        logic [7:0]  b [6];
        r = '0;
        for (int i = 0; i < 6; i++) b[i] = rx[47 - 8 * i -: 8];
        case (kind)
            REQ_TICK: begin
                if (ticks_since_hum != 16'hFFFF) ticks_since_hum = ticks_since_hum + 16'd1;
                if (cfg_interval != 32'd0) begin
                    if (interval_count > 32'd1) begin
                        interval_count = interval_count - 32'd1;
                    end else begin
                        interval_count = cfg_interval;
                        r.event_code   = event_now();
                    end
                end
                // The command delay only runs while the bus is free.
                if (!xfer_pending) begin
                    if (wait_ticks != 16'd0) wait_ticks = wait_ticks - 16'd1;
                    if (wait_ticks == 16'd0) begin
                        xfer_pending = 1'b1;
                        r.xfer_len   = 3'd2;
                        case (seq_phase)
                            PH_FEATURE_WRITE: r.xfer_bytes = {CMD_FEATURE_SET, 24'd0};
                            PH_FEATURE_READ: begin
                                r.xfer_read = 1'b1;
                                r.xfer_len  = 3'd3;
                            end
                            PH_INIT_AQ: r.xfer_bytes = {CMD_INIT_AQ, 24'd0};
                            PH_HUMIDITY: begin
                                r.xfer_len      = 3'd5;
                                r.xfer_bytes    = {CMD_SET_HUM, cfg_hum,
                                                   crc_pair(cfg_hum[15:8], cfg_hum[7:0])};
                                ticks_since_hum = 16'd0;
                            end
                            PH_MEASURE: r.xfer_bytes = {CMD_MEASURE, 24'd0};
                            PH_READ_AQ: begin
                                r.xfer_read = 1'b1;
                                r.xfer_len  = 3'd6;
                            end
                            default: enter_backoff();
                        endcase
                        if (xfer_pending) begin
                            r.xfer_start = 1'b1;
                            r.xfer_addr  = cfg_addr;
                        end else begin
                            r.xfer_len = 3'd0;
                        end
                    end
                end
            end
            REQ_XFER_DONE: begin
                // A completion with nothing on the bus is dropped.
                if (xfer_pending) begin
                    xfer_pending = 1'b0;
                    if (!ok) begin
                        enter_backoff();
                    end else if (seq_phase == PH_FEATURE_READ &&
                                 (crc_update(crc_pair(b[0], b[1]), b[2]) != 8'h00 ||
                                  b[0] != FEATURE_HI ||
                                  (b[1] != FEATURE_LO_A && b[1] != FEATURE_LO_B))) begin
                        enter_backoff();
                    end else if (seq_phase == PH_READ_AQ) begin
                        if (crc_update(crc_pair(b[0], b[1]), b[2]) != 8'h00 ||
                            crc_update(crc_pair(b[3], b[4]), b[5]) != 8'h00) begin
                            enter_backoff();
                        end else begin
                            latched_co2  = {b[0], b[1]};
                            latched_tvoc = {b[3], b[4]};
                            have_reading = 1'b1;
                            seq_phase    = PH_HUMIDITY;
                            // The next humidity write keeps the period; if it is
                            // already overdue it goes out on the next tick.
                            if (ticks_since_hum >= MEASURE_PERIOD_DEF)
                                wait_ticks = 16'd0;
                            else
                                wait_ticks = 16'(MEASURE_PERIOD_DEF) - ticks_since_hum;
                        end
                    end else begin
                        seq_phase  = t_phase'(seq_phase + 3'd1);
                        wait_ticks = 16'(COMMAND_DELAY_DEF);
                    end
                end
            end
            REQ_MEASURE: r.event_code = event_now();
            default: ;
        endcase
        r.co2eq_ppm     = latched_co2;
        r.tvoc_ppb      = latched_tvoc;
        r.reading_valid = have_reading;
        r.error_seen    = had_error;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic logic [47:0] noise48();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t[47:0];
    endfunction

    // Bytes a healthy sensor would return for the transfer now on the bus.
    function automatic logic [47:0] good_reply();
        logic [47:0] d;
        logic [7:0]  ver;
        logic [15:0] w1, w2;
        d = noise48();
        if (seq_phase == PH_FEATURE_READ) begin
            ver      = $urandom_range(0, 1) ? FEATURE_LO_A : FEATURE_LO_B;
            d[47:24] = {FEATURE_HI, ver, crc_pair(FEATURE_HI, ver)};
        end else if (seq_phase == PH_READ_AQ) begin
            w1 = 16'($urandom);
            w2 = 16'($urandom);
            d  = {w1, crc_pair(w1[15:8], w1[7:0]), w2, crc_pair(w2[15:8], w2[7:0])};
        end
        return d;
    endfunction

    // Sends one request and, once it is taken, queues the result it must cause.
    task automatic send_request(input logic [1:0] kind, input logic ok,
                                input logic [47:0] rx);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {7'd0, rx, ok};
        do @(posedge clk); while (!s_ready);
        due_reports.push_back(sequencer_step(kind, ok, rx));
    endtask

    // Registers change only with nothing in flight; the pause covers the two
    // register stages of the block.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        s_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEVICE_ADDRESS:  cfg_addr = val[6:0];
            CFG_HUMIDITY_COMP:   cfg_hum = val[15:0];
            CFG_UPDATE_INTERVAL: begin
                cfg_interval   = val;
                interval_count = val;
            end
            default: ;
        endcase
    endtask

    // Chooses the next request. While a transfer is on the bus, half of the
    // requests complete it with a well-formed reply; fault_pct of those are
    // spoiled by a bus error, a flipped bit or a wrong feature word.
    task automatic pick_request(input int fault_pct, output logic [1:0] kind,
                                output logic ok, output logic [47:0] rx);
        int         roll;
        logic [7:0] hi, lo;
        roll = $urandom_range(0, 99);
        rx   = noise48();
        ok   = 1'($urandom_range(0, 1));
        if (xfer_pending && roll < 50) begin
            kind = REQ_XFER_DONE;
            ok   = 1'b1;
            rx   = good_reply();
            if ($urandom_range(0, 99) < fault_pct) begin
                case ($urandom_range(0, 2))
                    0: ok = 1'b0;
                    1: rx = rx ^ (48'd1 << $urandom_range(24, 47));
                    default: begin
                        hi       = 8'($urandom);
                        lo       = 8'($urandom);
                        rx[47:24] = {hi, lo, crc_pair(hi, lo)};
                    end
                endcase
            end
        end else if (roll < 88) begin
            kind = REQ_TICK;
        end else if (roll < 94) begin
            kind = REQ_MEASURE;
        end else if (roll < 97 && !xfer_pending) begin
            kind = REQ_XFER_DONE;
        end else begin
            kind = REQ_UNUSED;
        end
    endtask

    task automatic drive_items(input int count, input int fault_pct);
        logic [1:0]  kind;
        logic        ok;
        logic [47:0] rx;
        repeat (count) begin
            pick_request(fault_pct, kind, ok, rx);
            send_request(kind, ok, rx);
        end
    endtask

    // Runs the sequence cleanly until the six-byte read is on the bus.
    task automatic run_to_sensor_read();
        while (!(xfer_pending && seq_phase == PH_READ_AQ)) begin
            if (xfer_pending)
                send_request(REQ_XFER_DONE, 1'b1, good_reply());
            else
                send_request(REQ_TICK, 1'b0, noise48());
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Requests that must not disturb a sequencer that has nothing on the bus.
    task automatic test_ignored_requests();
        send_request(REQ_UNUSED, 1'b1, '1);
        send_request(REQ_MEASURE, 1'b0, '0);
        send_request(REQ_XFER_DONE, 1'b1, '1);
        send_request(REQ_XFER_DONE, 1'b0, '0);
        send_request(REQ_XFER_DONE, 1'b1,
                     {FEATURE_HI, FEATURE_LO_A, crc_pair(FEATURE_HI, FEATURE_LO_A), 24'd0});
        repeat (4) send_request(REQ_TICK, 1'b0, '1);
        // The interval fires on every tick but has nothing to report yet.
        write_reg(CFG_UPDATE_INTERVAL, 32'd1);
        repeat (4) send_request(REQ_TICK, 1'b1, '0);
        send_request(REQ_MEASURE, 1'b1, '1);
        send_request(REQ_UNUSED, 1'b0, '0);
    endtask

    // Whole start-up sequence without faults, at the top address and humidity word.
    task automatic test_clean_sequence();
        write_reg(CFG_DEVICE_ADDRESS, 32'hFFFF_FFFF);
        write_reg(CFG_HUMIDITY_COMP, 32'h0000_FFFF);
        run_to_sensor_read();
        send_request(REQ_XFER_DONE, 1'b1, good_reply());
        drive_items(40, 0);
    endtask

    // Frequent bus errors, bad CRCs and wrong feature words, with the back-off.
    task automatic test_bus_failures();
        write_reg(CFG_DEVICE_ADDRESS, 32'd0);
        write_reg(CFG_HUMIDITY_COMP, 32'd0);
        write_reg(CFG_UPDATE_INTERVAL, 32'hFFFF_FFFF);
        drive_items(200, 35);
    endtask

    // Mostly healthy traffic under a few random register settings.
    task automatic test_random_traffic();
        repeat (2) begin
            write_reg(CFG_DEVICE_ADDRESS, $urandom);
            write_reg(CFG_HUMIDITY_COMP, $urandom);
            write_reg(CFG_UPDATE_INTERVAL,
                      ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(2, 60));
            drive_items(160, 8);
        end
    endtask

    // Requests and results moving on every cycle, with no idling on either side.
    task automatic test_back_to_back();
        no_idle = 1'b1;
        write_reg(CFG_UPDATE_INTERVAL, 32'd7);
        drive_items(120, 10);
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial begin
        rst_n      = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        s_user     = REQ_TICK;
        cfg_we     = 1'b0;
        cfg_index  = CFG_DEVICE_ADDRESS;
        cfg_wdata  = '0;
        no_idle    = 1'b0;
        mismatches = 0;

        seq_phase       = PH_FEATURE_WRITE;
        xfer_pending    = 1'b0;
        wait_ticks      = 16'(START_DELAY_DEF);
        ticks_since_hum = 16'd0;
        interval_count  = 32'd0;
        latched_co2     = 16'd0;
        latched_tvoc    = 16'd0;
        have_reading    = 1'b0;
        had_error       = 1'b0;
        cfg_addr        = DEVICE_ADDRESS_RST;
        cfg_hum         = 16'd0;
        cfg_interval    = 32'd0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_ignored_requests();
        test_clean_sequence();
        test_bus_failures();
        test_random_traffic();
        test_back_to_back();

        s_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------------

    // Receiver stalls come in bursts, each started at random while no_idle is clear.
    initial begin
        m_ready    = 1'b0;
        stall_left = 0;
    end

    always @(posedge clk) begin
        if (!no_idle && stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 5);
            m_ready    <= 1'b0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            m_ready    <= 1'b1;
        end
    end

    function automatic void compare_field(input string name, input logic [39:0] want,
                                          input logic [39:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // Each accepted result is matched against the oldest prediction.
    always @(posedge clk) begin
        t_seq_report got;
        t_seq_report want;
        if (rst_n && m_valid && m_ready) begin
            got = m_data;
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: result with none expected, got %h", $time, m_data);
            end else begin
                want = due_reports.pop_front();
                compare_field("xfer_start", want.xfer_start, got.xfer_start);
                compare_field("xfer_read", want.xfer_read, got.xfer_read);
                compare_field("xfer_addr", want.xfer_addr, got.xfer_addr);
                compare_field("xfer_len", want.xfer_len, got.xfer_len);
                compare_field("xfer_bytes", want.xfer_bytes, got.xfer_bytes);
                compare_field("co2eq_ppm", want.co2eq_ppm, got.co2eq_ppm);
                compare_field("tvoc_ppb", want.tvoc_ppb, got.tvoc_ppb);
                compare_field("reading_valid", want.reading_valid, got.reading_valid);
                compare_field("error_seen", want.error_seen, got.error_seen);
                compare_field("event_code", want.event_code, got.event_code);
            end
        end
    end

    // Hang detection: too long without a request or a result moving.
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
